/* hdl/mdst_pkg.sv */
// ----------------------------------------------------------------------------
// mdst_pkg
// Shared types and constants of the motion detector with sleep timer.
// ----------------------------------------------------------------------------
package mdst_pkg;

	localparam int AXES             = 3;
	localparam int PORT_SAMPLE_BITS = 16;
	localparam int PORT_TIME_BITS   = 32;
	localparam int THRESH_BITS      = 18;
	localparam int DEV_BITS         = 18;
	localparam int IN_DATA_BITS     = 80;
	localparam int OUT_DATA_BITS    = 72;
	localparam int RES_BITS         = 68;
	localparam int APB_ADDR_BITS    = 4;
	localparam int APB_DATA_BITS    = 32;

	localparam logic [THRESH_BITS-1:0]    THRESHOLD_RST  = 18'd204;
	localparam logic [PORT_TIME_BITS-1:0] TIMEOUT_RST    = 32'd500;
	localparam logic                      AUTO_START_RST = 1'b1;

	typedef enum logic [1:0] {
		REG_THRESHOLD  = 2'd0,
		REG_TIMEOUT    = 2'd1,
		REG_AUTO_START = 2'd2
	} reg_idx_t;

	// One input item as it moves down the pipeline. Axis 0 is x.
	typedef struct packed {
		logic                                        query;
		logic [AXES-1:0][PORT_SAMPLE_BITS-1:0]       sample;
		logic [PORT_TIME_BITS-1:0]                   now_ms;
	} item_t;

	typedef struct packed {
		logic [THRESH_BITS-1:0]    threshold;
		logic [PORT_TIME_BITS-1:0] timeout_ms;
		logic                      auto_start;
	} cfg_t;

	// Result item, laid out so that moved sits in bit 0.
	typedef struct packed {
		logic                                  asleep;
		logic [AXES-1:0][PORT_SAMPLE_BITS-1:0] avg;
		logic [DEV_BITS-1:0]                   dev;
		logic                                  moved;
	} res_t;

endpackage

/* hdl/motion_detect_sleep_timer.sv */
// ----------------------------------------------------------------------------
// motion_detect_sleep_timer
// Three-axis moving-average motion detector with a millisecond sleep timer.
// ----------------------------------------------------------------------------
// A result reaches m_tvalid from its input transfer through stages s1 to s7 and the output register.
// Throughput: one item per cycle; the ring memory read at accept and the
// write-back one stage later keep one sample per cycle against the ring.
// A stall at the output freezes the whole pipeline.
// Reset clears the slot pointer, ring fill flags and motion record, presets cfg;
// the ring memory is not cleared, the first sample stands in for all entries.
module motion_detect_sleep_timer
	import mdst_pkg::*;
#(
	parameter int RING_DEPTH  = 8,
	parameter int SAMPLE_BITS = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// sample_x[15:0], sample_y[31:16], sample_z[47:32], now_ms[79:48]
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// func[0]
	input  logic [0:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// moved[0], deviation_sum[18:1], avg_x[34:19], avg_y[50:35],
	// avg_z[66:51], asleep[67], zero[71:68]
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int SUM_BITS = SAMPLE_BITS + $clog2(RING_DEPTH);

	logic                          adv;
	item_t                         in_item;
	cfg_t                          cfg;
	logic                          v_s2, v_s5;
	item_t                         item_s2, item_s5;
	logic signed [SUM_BITS-1:0]    sum_s2 [AXES];
	logic signed [SAMPLE_BITS-1:0] avg_s5 [AXES];
	res_t                          out_res;

	assign pready = 1'b1;

	// The pipeline moves whenever the output register is free or drained.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	assign in_item.query     = s_tuser[0];
	assign in_item.sample[0] = s_tdata[15:0];
	assign in_item.sample[1] = s_tdata[31:16];
	assign in_item.sample[2] = s_tdata[47:32];
	assign in_item.now_ms    = s_tdata[79:48];

	assign m_tdata = {(OUT_DATA_BITS - RES_BITS)'(0), out_res};

	mdst_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	mdst_ring #(
		.RING_DEPTH  (RING_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_BITS    (SUM_BITS)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.in_item  (in_item),
		.v_s2     (v_s2),
		.item_s2  (item_s2),
		.sum_s2   (sum_s2)
	);

	mdst_avg #(
		.RING_DEPTH  (RING_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_BITS    (SUM_BITS)
	) u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_s2    (v_s2),
		.item_s2 (item_s2),
		.sum_s2  (sum_s2),
		.v_s5    (v_s5),
		.item_s5 (item_s5),
		.avg_s5  (avg_s5)
	);

	mdst_decide #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.v_s5      (v_s5),
		.item_s5   (item_s5),
		.avg_s5    (avg_s5),
		.out_valid (m_tvalid),
		.out_res   (out_res)
	);

endmodule

/* hdl/mdst_regs.sv */
// ----------------------------------------------------------------------------
// mdst_regs
// APB register file: motion threshold, sleep timeout and auto-start mode.
// ----------------------------------------------------------------------------
module mdst_regs
	import mdst_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output cfg_t                     cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= THRESHOLD_RST;
			cfg_q.timeout_ms <= TIMEOUT_RST;
			cfg_q.auto_start <= AUTO_START_RST;
		end else if (wr_en) begin
			case (idx)
				REG_THRESHOLD:  cfg_q.threshold  <= pwdata[THRESH_BITS-1:0];
				REG_TIMEOUT:    cfg_q.timeout_ms <= pwdata[PORT_TIME_BITS-1:0];
				REG_AUTO_START: cfg_q.auto_start <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THRESHOLD:  prdata = APB_DATA_BITS'(cfg_q.threshold);
			REG_TIMEOUT:    prdata = APB_DATA_BITS'(cfg_q.timeout_ms);
			REG_AUTO_START: prdata = APB_DATA_BITS'(cfg_q.auto_start);
			default:        prdata = '0;
		endcase
	end

endmodule

/* hdl/mdst_ring.sv */
// ----------------------------------------------------------------------------
// mdst_ring
// Sample ring memory with running per-axis sums (read, modify, write back).
// ----------------------------------------------------------------------------
module mdst_ring
	import mdst_pkg::*;
#(
	parameter int RING_DEPTH  = 8,
	parameter int SAMPLE_BITS = 16,
	parameter int SUM_BITS    = 19
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  item_t                      in_item,
	output logic                       v_s2,
	output item_t                      item_s2,
	output logic signed [SUM_BITS-1:0] sum_s2 [AXES]
);

	localparam int SLOT_BITS = $clog2(RING_DEPTH);
	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(RING_DEPTH - 1);
	localparam logic signed [SUM_BITS-1:0] DEPTH_S = SUM_BITS'(RING_DEPTH);

	logic [AXES*SAMPLE_BITS-1:0] mem [RING_DEPTH];

	logic [SLOT_BITS-1:0]          slot_q;
	logic                          primed_q;
	logic                          wrapped_q;
	logic signed [SAMPLE_BITS-1:0] first_q [AXES];
	logic signed [SUM_BITS-1:0]    sum_q   [AXES];

	logic                          v_s1;
	item_t                         item_s1;
	logic [SLOT_BITS-1:0]          slot_s1;
	logic                          fresh_s1;
	logic                          stale_s1;
	logic [AXES*SAMPLE_BITS-1:0]   rd_s1;

	logic                          acc_sample;
	logic                          upd_s1;
	logic [AXES*SAMPLE_BITS-1:0]   wr_word;
	logic signed [SAMPLE_BITS-1:0] new_smp [AXES];
	logic signed [SAMPLE_BITS-1:0] old_smp [AXES];
	logic signed [SUM_BITS-1:0]    sum_nxt [AXES];

	assign acc_sample = adv && in_valid && !in_item.query;
	assign upd_s1     = adv && v_s1 && !item_s1.query;

	// Slots advance in order; until the first wrap, an entry that was not
	// rewritten counts as holding the first sample, which first_q stands in for.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			primed_q  <= 1'b0;
			wrapped_q <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			if (acc_sample) begin
				primed_q <= 1'b1;
				if (slot_q == LAST_SLOT) begin
					slot_q    <= '0;
					wrapped_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (adv) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_sample && !primed_q) begin
			for (int a = 0; a < AXES; a++) begin
				first_q[a] <= in_item.sample[a][SAMPLE_BITS-1:0];
			end
		end
		if (adv) begin
			item_s1  <= in_item;
			slot_s1  <= slot_q;
			fresh_s1 <= !primed_q;
			stale_s1 <= !wrapped_q;
			item_s2  <= item_s1;
			sum_s2   <= sum_nxt;
		end
		if (upd_s1) begin
			sum_q <= sum_nxt;
		end
	end

	// Ring memory: one read port, one write port.
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= mem[slot_q];
		end
		if (upd_s1) begin
			mem[slot_s1] <= wr_word;
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			new_smp[a] = item_s1.sample[a][SAMPLE_BITS-1:0];
			old_smp[a] = stale_s1 ? first_q[a] : rd_s1[a*SAMPLE_BITS +: SAMPLE_BITS];
			wr_word[a*SAMPLE_BITS +: SAMPLE_BITS] = new_smp[a];
			if (fresh_s1) begin
				sum_nxt[a] = SUM_BITS'(new_smp[a]) * DEPTH_S;
			end else begin
				sum_nxt[a] = sum_q[a] - SUM_BITS'(old_smp[a]) + SUM_BITS'(new_smp[a]);
			end
		end
	end

endmodule

/* hdl/mdst_avg.sv */
// ----------------------------------------------------------------------------
// mdst_avg
// Ring average: sum divided by the ring depth, truncated toward zero, done
// as magnitude times a reciprocal over three stages.
// ----------------------------------------------------------------------------
module mdst_avg
	import mdst_pkg::*;
#(
	parameter int RING_DEPTH  = 8,
	parameter int SAMPLE_BITS = 16,
	parameter int SUM_BITS    = 19
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          v_s2,
	input  item_t                         item_s2,
	input  logic signed [SUM_BITS-1:0]    sum_s2 [AXES],
	output logic                          v_s5,
	output item_t                         item_s5,
	output logic signed [SAMPLE_BITS-1:0] avg_s5 [AXES]
);

	localparam int DEPTH_LOG  = $clog2(RING_DEPTH);
	localparam int SHIFT      = SUM_BITS + DEPTH_LOG;
	localparam int RECIP_BITS = SUM_BITS + 1;
	localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
	// Rounded-up reciprocal; exact for every magnitude below 2**SUM_BITS.
	localparam logic [RECIP_BITS-1:0] RECIP =
		RECIP_BITS'(((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

	logic                   v_s3, v_s4;
	item_t                  item_s3, item_s4;
	logic [SUM_BITS-1:0]    mag_s3 [AXES];
	logic                   neg_s3 [AXES];
	logic [SAMPLE_BITS-1:0] quo_s4 [AXES];
	logic                   neg_s4 [AXES];
	logic [PROD_BITS-1:0]   prod   [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			prod[a] = PROD_BITS'(mag_s3[a]) * PROD_BITS'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3 <= item_s2;
			item_s4 <= item_s3;
			item_s5 <= item_s4;
			for (int a = 0; a < AXES; a++) begin
				neg_s3[a] <= sum_s2[a][SUM_BITS-1];
				mag_s3[a] <= sum_s2[a][SUM_BITS-1] ? SUM_BITS'(-sum_s2[a])
				                                   : SUM_BITS'(sum_s2[a]);
				neg_s4[a] <= neg_s3[a];
				quo_s4[a] <= prod[a][SHIFT +: SAMPLE_BITS];
				avg_s5[a] <= neg_s4[a] ? -quo_s4[a] : quo_s4[a];
			end
		end
	end

endmodule

/* hdl/mdst_decide.sv */
// ----------------------------------------------------------------------------
// mdst_decide
// Deviation from the averages, motion threshold, motion time and sleep
// decision, ending in the output register.
// ----------------------------------------------------------------------------
module mdst_decide
	import mdst_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  cfg_t                          cfg,
	input  logic                          v_s5,
	input  item_t                         item_s5,
	input  logic signed [SAMPLE_BITS-1:0] avg_s5 [AXES],
	output logic                          out_valid,
	output res_t                          out_res
);

	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	localparam int SUMD_BITS = SAMPLE_BITS + 2;

	logic                          v_s6, v_s7;
	item_t                         item_s6, item_s7;
	logic signed [SAMPLE_BITS-1:0] avg_s6 [AXES];
	logic signed [SAMPLE_BITS-1:0] avg_s7 [AXES];
	logic signed [DIFF_BITS-1:0]   diff_s6 [AXES];
	logic [SAMPLE_BITS-1:0]        ad_s7 [AXES];
	logic signed [SAMPLE_BITS-1:0] smp_s5 [AXES];

	logic                 out_valid_q;
	res_t                 res_q;
	logic [TIME_BITS-1:0] last_q;
	logic                 seen_q;

	logic [SUMD_BITS-1:0] dev;
	logic [TIME_BITS-1:0] elapsed;
	logic                 moved;
	logic                 timer_sleep;
	res_t                 res_nxt;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			smp_s5[a] = item_s5.sample[a][SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s6 <= item_s5;
			item_s7 <= item_s6;
			avg_s6  <= avg_s5;
			avg_s7  <= avg_s6;
			for (int a = 0; a < AXES; a++) begin
				diff_s6[a] <= DIFF_BITS'(avg_s5[a]) - DIFF_BITS'(smp_s5[a]);
				ad_s7[a]   <= diff_s6[a][DIFF_BITS-1] ? SAMPLE_BITS'(-diff_s6[a])
				                                      : SAMPLE_BITS'(diff_s6[a]);
			end
		end
	end

	// A moving sample resets the timer to zero elapsed, so it never sleeps.
	always_comb begin
		dev = SUMD_BITS'(ad_s7[0]) + SUMD_BITS'(ad_s7[1]) + SUMD_BITS'(ad_s7[2]);
		elapsed = item_s7.now_ms[TIME_BITS-1:0] - last_q;
		timer_sleep = seen_q && (PORT_TIME_BITS'(elapsed) > cfg.timeout_ms);
		moved = !item_s7.query && (THRESH_BITS'(dev) > cfg.threshold);
		res_nxt.moved  = moved;
		res_nxt.asleep = !moved && ((cfg.auto_start && !seen_q) || timer_sleep);
		res_nxt.dev    = item_s7.query ? '0 : DEV_BITS'(dev);
		for (int a = 0; a < AXES; a++) begin
			res_nxt.avg[a] = item_s7.query ? '0 : PORT_SAMPLE_BITS'(avg_s7[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= '0;
			seen_q      <= 1'b0;
		end else if (adv) begin
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
			if (v_s7 && moved) begin
				last_q <= item_s7.now_ms[TIME_BITS-1:0];
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

/* hdl/mdst_checker.sv */
// ----------------------------------------------------------------------------
// mdst_port_props
// Port-level checks of the motion detector, bound to the top level.
// ----------------------------------------------------------------------------
module mdst_port_props
	import mdst_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata
);

	// A result that is not taken stays as it is.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An empty output stage never holds back the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// Movement restarts the timer, so a moving sample never reports sleep.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[67]))
		else $error("moved and asleep together");

	// Movement needs a deviation above a threshold that is at least zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[18:1] != '0)
		else $error("moved with zero deviation");

endmodule

bind motion_detect_sleep_timer mdst_port_props u_mdst_port_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
